FILE: hdl/code128_b_c_encoder_core_macros.svh
// Assertion macros for the Code 128 set B/C encoder.
// Used by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef CODE128_B_C_ENCODER_CORE_MACROS_SVH
`define CODE128_B_C_ENCODER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cb_pkg.sv
// Shared types, constants and the symbol pattern table of the Code 128 encoder.
// No dependencies.
`timescale 1ns / 1ps

package cb_pkg;

  localparam int MAX_CHARS = 100;
  localparam int CNT_W     = 7;
  localparam int ADDR_W    = 7;
  localparam int SYM_W     = 7;
  localparam int DIG_W     = 4;
  localparam int PAT_W     = 21;

  localparam logic [SYM_W-1:0] SYM_TO_C    = 7'd99;
  localparam logic [SYM_W-1:0] SYM_TO_B    = 7'd100;
  localparam logic [SYM_W-1:0] SYM_START_B = 7'd104;
  localparam logic [SYM_W-1:0] SYM_START_C = 7'd105;
  localparam logic [SYM_W-1:0] SYM_STOP    = 7'd106;
  localparam logic [SYM_W-1:0] SYM_DIGIT0  = 7'd16;
  localparam logic [SYM_W-1:0] CKS_MOD     = 7'd103;

  // Reciprocal of the checksum modulus, scaled by two to the CKS_SHIFT.
  localparam int CKS_SHIFT = 20;
  localparam logic [13:0] CKS_RECIP = 14'd10180;

  typedef enum logic [1:0] {
    CMD_DIG,
    CMD_CHR,
    CMD_OVF
  } cmd_kind_e;

  typedef enum logic [1:0] {
    SET_IDLE,
    SET_B,
    SET_C
  } code_set_e;

  // One classified character handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_e        kind;
    logic [SYM_W-1:0] val;
    logic             last;
  } cmd_t;

  // Widths w1..w7 as octal digits, w1 most significant.
  localparam logic [PAT_W-1:0] PATTERNS [107] = '{
    21'o2122220, 21'o2221220, 21'o2222210, 21'o1212230, 21'o1213220, 21'o1312220,
    21'o1222130, 21'o1223120, 21'o1322120, 21'o2212130, 21'o2213120, 21'o2312120,
    21'o1122320, 21'o1221320, 21'o1222310, 21'o1132220, 21'o1231220, 21'o1232210,
    21'o2232110, 21'o2211320, 21'o2212310, 21'o2132120, 21'o2231120, 21'o3121310,
    21'o3112220, 21'o3211220, 21'o3212210, 21'o3122120, 21'o3221120, 21'o3222110,
    21'o2121230, 21'o2123210, 21'o2321210, 21'o1113230, 21'o1311230, 21'o1313210,
    21'o1123130, 21'o1321130, 21'o1323110, 21'o2113130, 21'o2311130, 21'o2313110,
    21'o1121330, 21'o1123310, 21'o1321310, 21'o1131230, 21'o1133210, 21'o1331210,
    21'o3131210, 21'o2113310, 21'o2311310, 21'o2131130, 21'o2133110, 21'o2131310,
    21'o3111230, 21'o3113210, 21'o3311210, 21'o3121130, 21'o3123110, 21'o3321110,
    21'o3141110, 21'o2214110, 21'o4311110, 21'o1112240, 21'o1114220, 21'o1211240,
    21'o1214210, 21'o1411220, 21'o1412210, 21'o1122140, 21'o1124120, 21'o1221140,
    21'o1224110, 21'o1421120, 21'o1422110, 21'o2412110, 21'o2211140, 21'o4131110,
    21'o2411120, 21'o1341110, 21'o1112420, 21'o1211420, 21'o1212410, 21'o1142120,
    21'o1241120, 21'o1242110, 21'o4112120, 21'o4211120, 21'o4212110, 21'o2121410,
    21'o2141210, 21'o4121210, 21'o1111430, 21'o1113410, 21'o1311410, 21'o1141130,
    21'o1143110, 21'o4111130, 21'o4113110, 21'o1131410, 21'o1141310, 21'o3111410,
    21'o4111310, 21'o2114120, 21'o2112140, 21'o2112320, 21'o2331112
  };

  function automatic logic [PAT_W-1:0] cb_widths(input logic [SYM_W-1:0] sym);
    logic [PAT_W-1:0] pat;
    pat = '0;
    if (sym <= SYM_STOP) begin
      pat = PATTERNS[sym];
    end
    return pat;
  endfunction

endpackage

FILE: hdl/cb_front.sv
// Front end: accepts characters, classifies them and tracks the message length.
// Depends on cb_pkg.
`timescale 1ns / 1ps

module cb_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               char_code_i,
  input  logic                     last_char_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output cb_pkg::cmd_t             q_cmd_o
);

  logic [cb_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                     ovf_q, ovf_d;
  logic                     acc;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i && !q_full_i;

  always_comb begin
    cnt_d         = cnt_q;
    ovf_d         = ovf_q;
    q_push_o      = 1'b0;
    q_cmd_o.kind  = cb_pkg::CMD_CHR;
    q_cmd_o.last  = last_char_i;
    q_cmd_o.val   = '0;
    if (char_code_i >= 8'd48 && char_code_i <= 8'd57) begin
      q_cmd_o.kind = cb_pkg::CMD_DIG;
      q_cmd_o.val  = 7'(char_code_i - 8'd48);
    end else if (char_code_i >= 8'd32 && char_code_i <= 8'd126) begin
      q_cmd_o.val  = 7'(char_code_i - 8'd32);
    end
    if (acc) begin
      if (ovf_q) begin
        // Abandoned message: swallow characters until the last one.
        if (last_char_i) begin
          ovf_d = 1'b0;
          cnt_d = '0;
        end
      end else if (cnt_q == cb_pkg::CNT_W'(cb_pkg::MAX_CHARS)) begin
        q_push_o     = 1'b1;
        q_cmd_o.kind = cb_pkg::CMD_OVF;
        if (last_char_i) begin
          cnt_d = '0;
        end else begin
          ovf_d = 1'b1;
        end
      end else begin
        q_push_o = 1'b1;
        cnt_d    = last_char_i ? '0 : cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

FILE: hdl/cb_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on cb_pkg.
`timescale 1ns / 1ps

module cb_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  cb_pkg::cmd_t cmd_i,
  output logic         full_o,
  output logic         valid_o,
  output cb_pkg::cmd_t cmd_o,
  input  logic         pop_i
);

  cb_pkg::cmd_t ent_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = ent_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= 2'(cnt_q + {1'b0, do_push} - {1'b0, do_pop});
    end
  end

endmodule

FILE: hdl/cb_cksum.sv
// Pipelined weighted checksum modulo 103, one symbol per cycle.
// Depends on cb_pkg.
`timescale 1ns / 1ps

module cb_cksum (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [cb_pkg::SYM_W-1:0] sym_i,
  input  logic [cb_pkg::SYM_W-1:0] pos_i,
  input  logic                     clear_i,
  output logic [cb_pkg::SYM_W-1:0] sum_o,
  output logic                     busy_o
);

  logic [cb_pkg::SYM_W-1:0] vm, w, wm;
  logic [13:0]              p_q, p2_q;
  logic [cb_pkg::SYM_W-1:0] q_q;
  logic [27:0]              prod;
  logic                     v1_q, v2_q;
  logic [13:0]              r;
  logic [cb_pkg::SYM_W-1:0] r7;
  logic [7:0]               s;
  logic [cb_pkg::SYM_W-1:0] sum_q, sum_d;

  // Reduced operands and weight, then the quotient estimate, remainder and sum.
  always_comb begin
    vm   = (sym_i >= cb_pkg::CKS_MOD) ? sym_i - cb_pkg::CKS_MOD : sym_i;
    w    = (pos_i == '0) ? 7'd1 : pos_i;
    wm   = (w >= cb_pkg::CKS_MOD) ? w - cb_pkg::CKS_MOD : w;
    prod = 28'(p_q) * 28'(cb_pkg::CKS_RECIP);
    // Quotient estimate is low by at most one, so one subtract corrects it.
    r    = p2_q - 14'(q_q) * 14'(cb_pkg::CKS_MOD);
    r7   = (r >= 14'(cb_pkg::CKS_MOD)) ? 7'(r - 14'(cb_pkg::CKS_MOD)) : r[6:0];
    s    = {1'b0, sum_q} + {1'b0, r7};
    sum_d = (s >= 8'(cb_pkg::CKS_MOD)) ? 7'(s - 8'(cb_pkg::CKS_MOD)) : s[6:0];
  end

  always_ff @(posedge clk_i) begin
    p_q  <= 14'(vm) * 14'(wm);
    p2_q <= p_q;
    q_q  <= prod[cb_pkg::CKS_SHIFT +: cb_pkg::SYM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      sum_q <= '0;
    end else if (clear_i) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      sum_q <= '0;
    end else begin
      v1_q <= push_i;
      v2_q <= v1_q;
      if (v2_q) sum_q <= sum_d;
    end
  end

  assign sum_o  = sum_q;
  assign busy_o = v1_q || v2_q;

endmodule

FILE: hdl/cb_back.sv
// Back end: digit store, symbol sequencer and output register.
// Depends on cb_pkg and cb_cksum.
`timescale 1ns / 1ps

module cb_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  cb_pkg::cmd_t             cmd_i,
  output logic                     cmd_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [cb_pkg::SYM_W-1:0] symbol_value_o,
  output logic [cb_pkg::PAT_W-1:0] widths_o,
  output logic                     last_symbol_o,
  output logic                     overflow_error_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FS   = 4'd1;
  localparam logic [3:0] S_SWC  = 4'd2;
  localparam logic [3:0] S_PRD  = 4'd3;
  localparam logic [3:0] S_PEM  = 4'd4;
  localparam logic [3:0] S_BRD  = 4'd5;
  localparam logic [3:0] S_BSW  = 4'd6;
  localparam logic [3:0] S_BEM  = 4'd7;
  localparam logic [3:0] S_AF   = 4'd8;
  localparam logic [3:0] S_CK   = 4'd9;
  localparam logic [3:0] S_STP  = 4'd10;
  localparam logic [3:0] S_OVF  = 4'd11;

  logic [3:0]                state_q, state_d;
  cb_pkg::code_set_e         set_q, set_d;
  logic [cb_pkg::SYM_W-1:0]  pos_q, pos_d;
  logic [cb_pkg::CNT_W-1:0]  run_q, run_d;
  logic [cb_pkg::ADDR_W-1:0] idx_q, idx_d;
  logic [cb_pkg::SYM_W-1:0]  cval_q, cval_d;
  logic                      last_q, last_d;
  logic                      is_chr_q, is_chr_d;
  logic                      chr_ph_q, chr_ph_d;

  logic [cb_pkg::DIG_W-1:0]  mem [cb_pkg::MAX_CHARS];
  logic [cb_pkg::DIG_W-1:0]  rd0_q, rd1_q;
  logic                      we, rd_en;
  logic [cb_pkg::ADDR_W-1:0] ra0, ra1;

  logic                      emit, emit_ovf, clear_all, out_free;
  logic [cb_pkg::SYM_W-1:0]  emit_sym, bval;
  logic [cb_pkg::SYM_W-1:0]  cks_sum;
  logic                      cks_busy;

  logic                      ov_q;
  logic [cb_pkg::SYM_W-1:0]  sym_q;
  logic [cb_pkg::PAT_W-1:0]  wid_q;
  logic                      lst_q, ovf_q;

  assign out_free = !ov_q || !out_stall_i;
  assign bval = chr_ph_q ? cval_q : cb_pkg::SYM_DIGIT0 + {3'b000, rd0_q};

  always_comb begin
    state_d   = state_q;
    set_d     = set_q;
    pos_d     = pos_q;
    run_d     = run_q;
    idx_d     = idx_q;
    cval_d    = cval_q;
    last_d    = last_q;
    is_chr_d  = is_chr_q;
    chr_ph_d  = chr_ph_q;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    rd_en     = 1'b0;
    ra0       = idx_q;
    ra1       = 7'(idx_q + 7'd1);
    emit      = 1'b0;
    emit_ovf  = 1'b0;
    emit_sym  = '0;
    clear_all = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          last_d    = cmd_i.last;
          cval_d    = cmd_i.val;
          is_chr_d  = 1'b0;
          case (cmd_i.kind)
            cb_pkg::CMD_DIG: begin
              if (run_q < cb_pkg::CNT_W'(cb_pkg::MAX_CHARS)) begin
                we    = 1'b1;
                run_d = run_q + 1'b1;
              end
              if (cmd_i.last) state_d = S_FS;
            end
            cb_pkg::CMD_CHR: begin
              is_chr_d = 1'b1;
              state_d  = S_FS;
            end
            cb_pkg::CMD_OVF: state_d = S_OVF;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FS: begin
        idx_d = '0;
        if (run_q >= 7'd4) begin
          state_d = (set_q != cb_pkg::SET_C) ? S_SWC : S_PRD;
        end else if (run_q != '0) begin
          state_d = S_BRD;
        end else begin
          state_d = S_AF;
        end
      end
      S_SWC: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_sym = (set_q == cb_pkg::SET_IDLE) ? cb_pkg::SYM_START_C : cb_pkg::SYM_TO_C;
          set_d    = cb_pkg::SET_C;
          state_d  = S_PRD;
        end
      end
      S_PRD: begin
        rd_en   = 1'b1;
        state_d = S_PEM;
      end
      S_PEM: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_sym = 7'({3'b000, rd0_q} * 7'd10) + {3'b000, rd1_q};
          idx_d    = 7'(idx_q + 7'd2);
          if (7'(idx_q + 7'd3) < run_q) begin
            state_d = S_PRD;
          end else if (7'(idx_q + 7'd2) < run_q) begin
            state_d = S_BRD;
          end else begin
            state_d = S_AF;
          end
        end
      end
      S_BRD: begin
        rd_en   = 1'b1;
        state_d = S_BSW;
      end
      S_BSW: begin
        if (set_q == cb_pkg::SET_B) begin
          state_d = S_BEM;
        end else if (out_free) begin
          emit     = 1'b1;
          emit_sym = (set_q == cb_pkg::SET_IDLE) ? cb_pkg::SYM_START_B : cb_pkg::SYM_TO_B;
          set_d    = cb_pkg::SET_B;
          state_d  = S_BEM;
        end
      end
      S_BEM: begin
        if (out_free) begin
          emit     = 1'b1;
          emit_sym = bval;
          if (chr_ph_q) begin
            chr_ph_d = 1'b0;
            state_d  = last_q ? S_CK : S_IDLE;
          end else begin
            idx_d   = 7'(idx_q + 7'd1);
            state_d = (7'(idx_q + 7'd1) < run_q) ? S_BRD : S_AF;
          end
        end
      end
      S_AF: begin
        run_d = '0;
        if (is_chr_q) begin
          chr_ph_d = 1'b1;
          state_d  = S_BSW;
        end else begin
          state_d = S_CK;
        end
      end
      S_CK: begin
        // Wait for the checksum pipeline to take in every earlier symbol.
        if (!cks_busy && out_free) begin
          emit     = 1'b1;
          emit_sym = cks_sum;
          state_d  = S_STP;
        end
      end
      S_STP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_sym  = cb_pkg::SYM_STOP;
          clear_all = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_OVF: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_ovf  = 1'b1;
          clear_all = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (emit && !emit_ovf) begin
      pos_d = pos_q + 1'b1;
    end
    if (clear_all) begin
      set_d    = cb_pkg::SET_IDLE;
      pos_d    = '0;
      run_d    = '0;
      chr_ph_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[run_q] <= cmd_i.val[cb_pkg::DIG_W-1:0];
    end
    if (rd_en) begin
      rd0_q <= mem[ra0];
      rd1_q <= mem[ra1];
    end
  end

  cb_cksum u_cksum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit && !emit_ovf),
    .sym_i   (emit_sym),
    .pos_i   (pos_q),
    .clear_i (clear_all),
    .sum_o   (cks_sum),
    .busy_o  (cks_busy)
  );

  // The overflow result is registered with a zero symbol value.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      sym_q <= emit_sym;
      wid_q <= emit_ovf ? '0 : cb_pkg::cb_widths(emit_sym);
      lst_q <= emit_ovf || (emit_sym == cb_pkg::SYM_STOP);
      ovf_q <= emit_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      set_q    <= cb_pkg::SET_IDLE;
      pos_q    <= '0;
      run_q    <= '0;
      idx_q    <= '0;
      cval_q   <= '0;
      last_q   <= 1'b0;
      is_chr_q <= 1'b0;
      chr_ph_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      set_q    <= set_d;
      pos_q    <= pos_d;
      run_q    <= run_d;
      idx_q    <= idx_d;
      cval_q   <= cval_d;
      last_q   <= last_d;
      is_chr_q <= is_chr_d;
      chr_ph_q <= chr_ph_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign symbol_value_o   = sym_q;
  assign widths_o         = wid_q;
  assign last_symbol_o    = lst_q;
  assign overflow_error_o = ovf_q;

endmodule

FILE: hdl/code128_b_c_encoder_core.sv
// Code 128 encoder (code sets B and C), top level.
// Depends on cb_pkg, cb_front, cb_queue, cb_back, cb_cksum and the macros header.
`timescale 1ns / 1ps

// The block takes one Latin-1 character per input transaction, with a flag on
// the final character of a message, and returns a stream of Code 128 symbols,
// each with its bar and space widths in modules. Printable characters go out
// in code set B; a byte below 32 or above 126 goes out as a space. Digits are
// held in an internal store until the run ends: a run of four or more becomes
// code set C pairs, with an odd final digit sent in set B. Start and
// code-switch symbols are inserted as needed, and the last character is
// followed by the modulo 103 checksum symbol and the stop symbol, whose width_7
// is the final two-module bar. A message longer than 100 characters ends in a
// single result with overflow_error and last_symbol set and all widths zero;
// characters after it are dropped up to and including the one marked last.
// Flow: the front end passes each accepted character into a two-entry command
// queue, so input is stalled only when that queue is full. A non-digit passes
// through S_FS, S_AF, S_BSW and S_BEM; a start or switch symbol into set B is
// sent in S_BSW, while a switch into set C takes its own state, S_SWC. A held
// digit run is read from the digit store with a registered read: each set C
// pair passes through S_PRD and S_PEM, each set B digit through S_BRD, S_BSW
// and S_BEM. The end of a message waits in S_CK while the checksum pipeline
// drains, then sends the checksum and stop symbols. A stalled output holds
// every emitting state. The output register lets the back end finish one
// symbol while the previous one waits to be taken.

`include "code128_b_c_encoder_core_macros.svh"

module code128_b_c_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] symbol_value_o,
  output logic [2:0] width_1_o,
  output logic [2:0] width_2_o,
  output logic [2:0] width_3_o,
  output logic [2:0] width_4_o,
  output logic [2:0] width_5_o,
  output logic [2:0] width_6_o,
  output logic [2:0] width_7_o,
  output logic       last_symbol_o,
  output logic       overflow_error_o
);

  logic                     q_full, q_push, q_valid, q_pop;
  cb_pkg::cmd_t             q_in, q_out;
  logic [cb_pkg::PAT_W-1:0] widths;

  // Front end: classification and message length tracking.
  cb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_in)
  );

  // Decouples character intake from symbol generation.
  cb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_out),
    .pop_i   (q_pop)
  );

  // Back end: digit store, symbol sequencing, checksum and output register.
  cb_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_i            (q_out),
    .cmd_pop_o        (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .symbol_value_o   (symbol_value_o),
    .widths_o         (widths),
    .last_symbol_o    (last_symbol_o),
    .overflow_error_o (overflow_error_o)
  );

  // The widths are packed with width_1 in the most significant digit.
  assign width_1_o = widths[20:18];
  assign width_2_o = widths[17:15];
  assign width_3_o = widths[14:12];
  assign width_4_o = widths[11:9];
  assign width_5_o = widths[8:6];
  assign width_6_o = widths[5:3];
  assign width_7_o = widths[2:0];

  // An overflow result carries no symbol and closes the message.
  `CB_ASSERT_NOW(a_ovf_shape, out_valid_o && overflow_error_o, last_symbol_o && symbol_value_o == 7'd0 && width_1_o == 3'd0, "overflow result malformed")
  // Only the stop symbol has a trailing bar, and only it ends a normal message.
  `CB_ASSERT_NOW(a_stop_bar, out_valid_o && !overflow_error_o, (symbol_value_o == 7'd106) == (width_7_o == 3'd2) && last_symbol_o == (symbol_value_o == 7'd106), "stop bar mismatch")
  // A finished message is never followed at once by another closing result.
  `CB_ASSERT_NEXT(a_end_gap, out_valid_o && last_symbol_o && !out_stall_i, !(out_valid_o && last_symbol_o), "back-to-back message ends")

endmodule
